FILE: design/fla_pkg.sv
package fla_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned AddrW       = 16;
  localparam int unsigned LenW        = 16;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [LenW-1:0] DefaultMemorySize = 16'd640;

  localparam logic [CfgIdxW-1:0] RegFitPolicy  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMemorySize = 1'b1;

  localparam logic [StatusW-1:0] StGranted    = 3'd0;
  localparam logic [StatusW-1:0] StNoFit      = 3'd1;
  localparam logic [StatusW-1:0] StInserted   = 3'd2;
  localparam logic [StatusW-1:0] StMergedNext = 3'd3;
  localparam logic [StatusW-1:0] StMergedPrev = 3'd4;
  localparam logic [StatusW-1:0] StMergedBoth = 3'd5;
  localparam logic [StatusW-1:0] StRejected   = 3'd6;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
  } seg_t;

  typedef struct packed {
    logic            mode;
    logic [LenW-1:0] block_length;
    logic [AddrW-1:0] block_start;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]   granted_start;
    logic [LenW-1:0]    granted_length;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FIX,
    S_INIT,
    S_OUT
  } state_e;

endpackage

FILE: design/fla_stream_if.sv
interface fla_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/fla_seg_ram.sv
module fla_seg_ram (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [fla_pkg::IdxW-1:0] waddr_i,
  input  fla_pkg::seg_t           wdata_i,
  input  logic [fla_pkg::IdxW-1:0] raddr_i,
  output fla_pkg::seg_t           rdata_o
);

  fla_pkg::seg_t mem_q [fla_pkg::MaxSegments];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/free_list_segment_allocator.sv
// Free-segment allocator with first-fit or best-fit placement and
// coalescing on release.
// Requests arrive on the req channel (mode, block_length, block_start)
// as valid/ready words; each request yields exactly one word on the rsp
// channel (granted_start, granted_length, status).
// The segment table lives in a single-port-write, single-port-read RAM
// with a registered read port. A request is first scanned (one read and
// one compare per entry, ending early when first fit or a right
// neighbour stops it), then decided; up to N entries (N the current
// segment count) are then moved one at a time to insert or remove a
// segment, the modified entry is written back and the response is loaded.
// One request is worked on at a time; the next is taken once the block
// is idle again.
// Reset loads fit_policy 1 and memory_size 640, and the block then writes
// one segment spanning all memory. Writing memory_size rebuilds the table
// the same way. A response held by a stalled receiver stays in its output
// register; the next request may be worked on meanwhile, but its response
// waits until the register has been taken.
module free_list_segment_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fla_stream_if.sink                  req,
  fla_stream_if.source                rsp,
  input  logic                        cfg_we_i,
  input  logic [fla_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fla_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = fla_pkg::IdxW;
  localparam int unsigned CntW = fla_pkg::CntW;
  localparam int unsigned AW   = fla_pkg::AddrW;
  localparam int unsigned LW   = fla_pkg::LenW;

  fla_pkg::state_e state_q, state_d;
  logic            policy_q, policy_d;
  logic [LW-1:0]   msize_q, msize_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;       // scan index / move index
  fla_pkg::req_t   req_q, req_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] pick_q, pick_d;
  fla_pkg::seg_t   pseg_q, pseg_d;     // picked or left segment
  fla_pkg::seg_t   rseg_q, rseg_d;     // right neighbour on release
  logic            rvalid_q, rvalid_d; // a read issued last cycle
  logic [CntW-1:0] rptr_q, rptr_d;
  logic            stop_q, stop_d;
  logic            dir_up_q, dir_up_d; // shift direction
  logic [CntW-1:0] mend_q, mend_d;
  fla_pkg::seg_t   fix_q, fix_d;
  logic [IdxW-1:0] fixa_q, fixa_d;
  logic [CntW-1:0] ncount_q, ncount_d;
  fla_pkg::rsp_t   ans_q, ans_d;       // answer waiting for the output register
  fla_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  fla_pkg::seg_t   wdata, rdata;

  fla_seg_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic [AW:0]   rel_end;
  logic [AW:0]   left_end;
  logic          left_ok, right_ok, ljoin, rjoin;
  logic [CntW-1:0] pos;

  assign rel_end  = {1'b0, req_q.block_start} + {1'b0, req_q.block_length};
  assign left_end = {1'b0, pseg_q.start} + {1'b0, pseg_q.len};
  assign pos      = ptr_q;
  assign left_ok  = !found_q || (left_end <= {1'b0, req_q.block_start});
  assign ljoin    = found_q && (left_end == {1'b0, req_q.block_start});
  assign right_ok = !rvalid_q || (rel_end <= {1'b0, rseg_q.start});
  assign rjoin    = rvalid_q && (rel_end == {1'b0, rseg_q.start});

  assign req.ready = (state_q == fla_pkg::S_IDLE) && !cfg_we_i;
  assign rsp.valid = rsp_valid_q;
  assign rsp.data  = rsp_q;

  // Decision after the scan; mirrors the datapath block below.
  function automatic fla_pkg::state_e next_after_decide();
    fla_pkg::state_e s;
    s = fla_pkg::S_OUT;
    if (!req_q.mode) begin
      if (found_q && pseg_q.len == req_q.block_length &&
          CntW'(pick_q) + 1'b1 < count_q) s = fla_pkg::S_MOVE_RD;
      else if (found_q) s = fla_pkg::S_FIX;
    end else if (req_q.block_length != '0 && rel_end <= {1'b0, msize_q} &&
                 left_ok && right_ok) begin
      if (ljoin && rjoin) s = (pos + 1'b1 < count_q) ? fla_pkg::S_MOVE_RD : fla_pkg::S_FIX;
      else if (ljoin || rjoin) s = fla_pkg::S_FIX;
      else if (count_q < CntW'(fla_pkg::MaxSegments))
        s = (pos < count_q) ? fla_pkg::S_MOVE_RD : fla_pkg::S_FIX;
    end
    return s;
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fla_pkg::S_IDLE:    if (req.valid && req.ready) state_d = fla_pkg::S_SCAN;
      fla_pkg::S_SCAN:    if (stop_d) state_d = fla_pkg::S_DECIDE;
      fla_pkg::S_DECIDE:  state_d = next_after_decide();
      fla_pkg::S_MOVE_RD: state_d = fla_pkg::S_MOVE_WR;
      fla_pkg::S_MOVE_WR: state_d = (ptr_d == mend_q) ? fla_pkg::S_FIX : fla_pkg::S_MOVE_RD;
      fla_pkg::S_FIX:     state_d = fla_pkg::S_OUT;
      fla_pkg::S_INIT:    state_d = fla_pkg::S_IDLE;
      fla_pkg::S_OUT:     if (!rsp_valid_q || rsp.ready) state_d = fla_pkg::S_IDLE;
      default:            state_d = fla_pkg::S_IDLE;
    endcase
    if (cfg_we_i && cfg_idx_i == fla_pkg::RegMemorySize) state_d = fla_pkg::S_INIT;
  end

  always_comb begin
    policy_d = policy_q;  msize_d = msize_q;  count_d = count_q;
    ptr_d = ptr_q;  req_d = req_q;  found_d = found_q;  pick_d = pick_q;
    pseg_d = pseg_q;  rseg_d = rseg_q;  rvalid_d = 1'b0;  rptr_d = rptr_q;
    stop_d = stop_q;  dir_up_d = dir_up_q;  mend_d = mend_q;
    fix_d = fix_q;  fixa_d = fixa_q;  ncount_d = ncount_q;
    ans_d = ans_q;  rsp_d = rsp_q;  rsp_valid_d = rsp_valid_q;
    we = 1'b0;  waddr = '0;  wdata = '0;  raddr = '0;

    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;

    unique case (state_q)
      fla_pkg::S_IDLE: begin
        if (req.valid && req.ready) begin
          req_d = req.data;  ptr_d = '0;  found_d = 1'b0;  stop_d = 1'b0;
          rptr_d = '0;
        end
      end
      fla_pkg::S_SCAN: begin
        // Issue reads at rptr; consume the word read last cycle.
        stop_d = stop_q;
        if (rvalid_q) begin
          if (!req_q.mode) begin
            if (req_q.block_length != '0 && rdata.len >= req_q.block_length &&
                (!found_q || (policy_q && rdata.len < pseg_q.len))) begin
              found_d = 1'b1;  pick_d = IdxW'(ptr_q);  pseg_d = rdata;
              if (!policy_q) stop_d = 1'b1;
            end
            ptr_d = ptr_q + 1'b1;
          end else begin
            if (rdata.start <= req_q.block_start) begin
              found_d = 1'b1;  pseg_d = rdata;  ptr_d = ptr_q + 1'b1;
            end else begin
              rseg_d = rdata;  stop_d = 1'b1;
            end
          end
        end
        if (!stop_d && !rvalid_q && rptr_q != count_q) begin
          raddr = IdxW'(rptr_q);  rvalid_d = 1'b1;  rptr_d = rptr_q + 1'b1;
        end else if (!stop_d && !rvalid_q) begin
          stop_d = 1'b1;
        end
        // Keep the right neighbour valid flag into the decide cycle.
        if (stop_d && rvalid_q && req_q.mode && !(rdata.start <= req_q.block_start))
          rvalid_d = 1'b1;
      end
      fla_pkg::S_DECIDE: begin
        rvalid_d = rvalid_q;
        ans_d = '{granted_start: '0, granted_length: '0, status: fla_pkg::StRejected};
        ncount_d = count_q;
        if (!req_q.mode) begin
          ans_d.status = fla_pkg::StNoFit;
          if (found_q) begin
            ans_d = '{granted_start: pseg_q.start, granted_length: req_q.block_length,
                      status: fla_pkg::StGranted};
            if (pseg_q.len == req_q.block_length) begin
              // Exact fit: pull the tail down over the picked entry.
              dir_up_d = 1'b0;  ptr_d = CntW'(pick_q) + 1'b1;  mend_d = count_q;
              ncount_d = count_q - 1'b1;
              fixa_d = IdxW'(count_q - 1'b1);  fix_d = '0;
            end else begin
              fixa_d = pick_q;
              fix_d.start = pseg_q.start + req_q.block_length;
              fix_d.len = pseg_q.len - req_q.block_length;
            end
          end
        end else if (req_q.block_length != '0 && rel_end <= {1'b0, msize_q} &&
                     left_ok && right_ok) begin
          if (ljoin && rjoin) begin
            ans_d.status = fla_pkg::StMergedBoth;
            dir_up_d = 1'b0;  ptr_d = pos + 1'b1;  mend_d = count_q;
            ncount_d = count_q - 1'b1;
            fixa_d = IdxW'(pos - 1'b1);
            fix_d.start = pseg_q.start;
            fix_d.len = pseg_q.len + req_q.block_length + rseg_q.len;
          end else if (ljoin) begin
            ans_d.status = fla_pkg::StMergedPrev;
            fixa_d = IdxW'(pos - 1'b1);
            fix_d.start = pseg_q.start;
            fix_d.len = pseg_q.len + req_q.block_length;
          end else if (rjoin) begin
            ans_d.status = fla_pkg::StMergedNext;
            fixa_d = IdxW'(pos);
            fix_d.start = req_q.block_start;
            fix_d.len = rseg_q.len + req_q.block_length;
          end else if (count_q < CntW'(fla_pkg::MaxSegments)) begin
            ans_d.status = fla_pkg::StInserted;
            dir_up_d = 1'b1;  ptr_d = count_q;  mend_d = pos;
            ncount_d = count_q + 1'b1;
            fixa_d = IdxW'(pos);
            fix_d.start = req_q.block_start;
            fix_d.len = req_q.block_length;
          end
        end
      end
      fla_pkg::S_MOVE_RD: begin
        raddr = dir_up_q ? IdxW'(ptr_q - 1'b1) : IdxW'(ptr_q);
      end
      fla_pkg::S_MOVE_WR: begin
        we = 1'b1;  wdata = rdata;
        if (dir_up_q) begin
          waddr = IdxW'(ptr_q);  ptr_d = ptr_q - 1'b1;
        end else begin
          waddr = IdxW'(ptr_q - 1'b1);  ptr_d = ptr_q + 1'b1;
        end
      end
      fla_pkg::S_FIX: begin
        we = 1'b1;  waddr = fixa_q;  wdata = fix_q;  count_d = ncount_q;
      end
      fla_pkg::S_OUT: begin
        // The answer moves out only once the previous word has been taken.
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;  rsp_d = ans_q;
        end
      end
      fla_pkg::S_INIT: begin
        we = 1'b1;  waddr = '0;  wdata = '{start: '0, len: msize_q};
        count_d = (msize_q != '0) ? CntW'(1) : '0;
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fla_pkg::RegFitPolicy:  policy_d = cfg_data_i[0];
        fla_pkg::RegMemorySize: msize_d = cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fla_pkg::S_INIT;
      policy_q    <= 1'b1;
      msize_q     <= fla_pkg::DefaultMemorySize;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      stop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      policy_q    <= policy_d;
      msize_q     <= msize_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      rvalid_q    <= rvalid_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;  req_q <= req_d;  found_q <= found_d;  pick_q <= pick_d;
    pseg_q <= pseg_d;  rseg_q <= rseg_d;  rptr_q <= rptr_d;
    dir_up_q <= dir_up_d;  mend_q <= mend_d;  fix_q <= fix_d;  fixa_q <= fixa_d;
    ncount_q <= ncount_d;  ans_q <= ans_d;  rsp_q <= rsp_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(fla_pkg::MaxSegments))
    else $error("segment count out of range");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_q))
    else $error("response word changed while waiting");

  a_rsp_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == fla_pkg::S_OUT)
    else $error("response raised outside output state");

endmodule

FILE: sim/tb_free_list_segment_allocator.sv
`timescale 1ns / 100ps

module tb_free_list_segment_allocator;

  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fla_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [fla_pkg::CfgDataW-1:0] cfg_data_i = '0;

  fla_stream_if #(.T(fla_pkg::req_t)) req ();
  fla_stream_if #(.T(fla_pkg::rsp_t)) rsp ();

  free_list_segment_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req.sink),
    .rsp        (rsp.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the free table and registers.
  logic [fla_pkg::AddrW-1:0] free_start[fla_pkg::MaxSegments];
  logic [fla_pkg::LenW-1:0]  free_len[fla_pkg::MaxSegments];
  int unsigned      free_count;
  logic             policy_best;
  logic [fla_pkg::LenW-1:0]  mem_size;

  fla_pkg::rsp_t answer_q[$];
  int   errors = 0;
  int   words_sent = 0;
  int   words_checked = 0;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;
  bit   no_gaps = 1'b0;
  int   status_seen[7];

  function automatic void table_clear();
    for (int i = 0; i < fla_pkg::MaxSegments; i++) begin
      free_start[i] = '0;
      free_len[i] = '0;
    end
    free_count = 0;
    if (mem_size != 0) begin
      free_len[0] = mem_size;
      free_count = 1;
    end
  endfunction

  function automatic void table_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < free_count; i++) begin
      free_start[i] = free_start[i+1];
      free_len[i] = free_len[i+1];
    end
    free_count--;
    free_start[free_count] = '0;
    free_len[free_count] = '0;
  endfunction

  function automatic fla_pkg::rsp_t allocator_answer(fla_pkg::req_t r);
    fla_pkg::rsp_t o;
    int unsigned pick;
    bit found;
    int unsigned pos;
    longint unsigned b, c, a;
    bit lj, rj;
    o = '0;
    pick = 0;
    found = 0;
    pos = 0;
    lj = 0;
    rj = 0;
    if (r.mode == 1'b0) begin
      o.status = fla_pkg::StNoFit;
      if (r.block_length == 0) return o;
      for (int unsigned i = 0; i < free_count; i++) begin
        if (free_len[i] >= r.block_length &&
            (!found || (policy_best && free_len[i] < free_len[pick]))) begin
          pick = i;
          found = 1;
          if (!policy_best) break;
        end
      end
      if (!found) return o;
      o.status = fla_pkg::StGranted;
      o.granted_start = free_start[pick];
      o.granted_length = r.block_length;
      if (free_len[pick] == r.block_length) begin
        table_drop(pick);
      end else begin
        free_start[pick] = free_start[pick] + r.block_length;
        free_len[pick] = free_len[pick] - r.block_length;
      end
      return o;
    end
    o.status = fla_pkg::StRejected;
    b = r.block_start;
    c = b + r.block_length;
    if (r.block_length == 0 || c > mem_size) return o;
    while (pos < free_count && free_start[pos] <= b) pos++;
    if (pos > 0) begin
      a = longint'(free_start[pos-1]) + free_len[pos-1];
      if (a > b) return o;
      lj = (a == b);
    end
    if (pos < free_count) begin
      if (c > free_start[pos]) return o;
      rj = (c == free_start[pos]);
    end
    if (lj && rj) begin
      free_len[pos-1] = free_len[pos-1] + r.block_length + free_len[pos];
      table_drop(pos);
      o.status = fla_pkg::StMergedBoth;
    end else if (lj) begin
      free_len[pos-1] = free_len[pos-1] + r.block_length;
      o.status = fla_pkg::StMergedPrev;
    end else if (rj) begin
      free_start[pos] = r.block_start;
      free_len[pos] = free_len[pos] + r.block_length;
      o.status = fla_pkg::StMergedNext;
    end else if (free_count < fla_pkg::MaxSegments) begin
      for (int unsigned i = free_count; i > pos; i--) begin
        free_start[i] = free_start[i-1];
        free_len[i] = free_len[i-1];
      end
      free_start[pos] = r.block_start;
      free_len[pos] = r.block_length;
      free_count++;
      o.status = fla_pkg::StInserted;
    end
    return o;
  endfunction

  // Receiver: random ready unless held off or gap-free, checks each word against the oldest answer.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, rsp.data);
          errors++;
        end else begin
          fla_pkg::rsp_t e;
          e = answer_q.pop_front();
          if (rsp.data.granted_start !== e.granted_start)
            begin $display("%0t: granted_start exp %h got %h", $time,
              e.granted_start, rsp.data.granted_start); errors++; end
          if (rsp.data.granted_length !== e.granted_length)
            begin $display("%0t: granted_length exp %h got %h", $time,
              e.granted_length, rsp.data.granted_length); errors++; end
          if (rsp.data.status !== e.status)
            begin $display("%0t: status exp %0d got %0d", $time,
              e.status, rsp.data.status); errors++; end
          words_checked++;
        end
      end
      if (hold_off) rsp.ready <= 1'b0;
      else if (no_gaps) rsp.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 4) rsp.ready <= 1'b0;
      else if (!rsp.ready) rsp.ready <= ($urandom_range(0, 3) == 0);
      else rsp.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // The valid line stays high after a word is taken; the block is busy then,
  // and the line drops before any gap or drain.
  task automatic send_word(logic m, logic [fla_pkg::LenW-1:0] l,
                           logic [fla_pkg::AddrW-1:0] s);
    fla_pkg::req_t r;
    int gap;
    r.mode = m;
    r.block_length = l;
    r.block_start = s;
    gap = 0;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    end
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    answer_q.push_back(allocator_answer(r));
    status_seen[answer_q[$].status]++;
    words_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fla_pkg::CfgIdxW-1:0] idx,
                           logic [fla_pkg::CfgDataW-1:0] d);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fla_pkg::RegFitPolicy) begin
      policy_best = d[0];
    end else begin
      mem_size = d;
      table_clear();
    end
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(1'b0, 16'd0, 16'd0);
    send_word(1'b0, 16'd700, 16'hffff);
    send_word(1'b0, 16'd100, 16'd0);
    send_word(1'b0, 16'd100, 16'd0);
    send_word(1'b1, 16'd0, 16'd10);
    send_word(1'b1, 16'd100, 16'd600);
    send_word(1'b1, 16'd50, 16'd150);
    send_word(1'b1, 16'd20, 16'd20);
    send_word(1'b1, 16'd30, 16'd80);
    send_word(1'b1, 16'd20, 16'd0);
    send_word(1'b1, 16'd40, 16'd40);
    send_word(1'b1, 16'd50, 16'd100);
    send_word(1'b0, 16'd640, 16'd0);
    send_word(1'b0, 16'd1, 16'd0);
    send_word(1'b1, 16'hffff, 16'hffff);
  endtask

  task automatic test_extremes();
    write_reg(fla_pkg::RegMemorySize, 16'hffff);
    write_reg(fla_pkg::RegFitPolicy, 16'd0);
    send_word(1'b0, 16'hffff, 16'd0);
    send_word(1'b0, 16'd1, 16'd0);
    send_word(1'b1, 16'hffff, 16'd0);
    send_word(1'b1, 16'h8000, 16'd0);
    send_word(1'b1, 16'd1, 16'hfffe);
    write_reg(fla_pkg::RegMemorySize, 16'd0);
    send_word(1'b0, 16'd1, 16'd0);
    send_word(1'b1, 16'd1, 16'd0);
    write_reg(fla_pkg::RegMemorySize, 16'd1);
    send_word(1'b0, 16'd1, 16'd0);
    send_word(1'b1, 16'd1, 16'd0);
  endtask

  // Fill the table with many one-unit holes, some past its capacity.
  task automatic test_table_full();
    write_reg(fla_pkg::RegMemorySize, 16'd100);
    send_word(1'b0, 16'd100, 16'd0);
    for (int i = 0; i < 20; i++) send_word(1'b1, 16'd1, 16'(i * 3));
    send_word(1'b1, 16'd1, 16'd1);
    send_word(1'b1, 16'd1, 16'd2);
  endtask

  task automatic test_back_pressure();
    write_reg(fla_pkg::RegMemorySize, 16'd640);
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) send_word(1'b0, 16'($urandom_range(1, 20)), 16'd0);
      end
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  // Allocations and releases of blocks previously granted, plus noise.
  task automatic test_random(int n, logic [fla_pkg::LenW-1:0] msize, bit phase_no_gaps);
    logic [fla_pkg::AddrW-1:0] held_s[$];
    logic [fla_pkg::LenW-1:0]  held_l[$];
    int k, sel;
    fla_pkg::rsp_t last;
    write_reg(fla_pkg::RegMemorySize, msize);
    no_gaps = phase_no_gaps;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_word(1'b0, 16'($urandom_range(0, msize / 6 + 1)), 16'($urandom));
        last = answer_q[$];
        if (last.status == fla_pkg::StGranted) begin
          // Keep split pieces so that releases can form gaps of their own.
          if (last.granted_length > 1 && $urandom_range(0, 1)) begin
            held_s.push_back(last.granted_start);
            held_l.push_back(last.granted_length / 2);
            held_s.push_back(last.granted_start + last.granted_length / 2);
            held_l.push_back(last.granted_length - last.granted_length / 2);
          end else begin
            held_s.push_back(last.granted_start);
            held_l.push_back(last.granted_length);
          end
        end
      end else if (sel < 88 && held_s.size() != 0) begin
        k = $urandom_range(0, held_s.size() - 1);
        send_word(1'b1, held_l[k], held_s[k]);
        held_s.delete(k);
        held_l.delete(k);
      end else if (sel < 94) begin
        send_word(1'b1, 16'($urandom_range(0, msize)), 16'($urandom_range(0, msize)));
      end else begin
        send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    policy_best = 1'b1;
    mem_size = fla_pkg::DefaultMemorySize;
    table_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extremes();
    test_table_full();
    test_back_pressure();
    write_reg(fla_pkg::RegFitPolicy, 16'd1);
    test_random(200, 16'd640, 1'b0);
    write_reg(fla_pkg::RegFitPolicy, 16'd0);
    test_random(200, 16'd1000, 1'b1);
    write_reg(fla_pkg::RegFitPolicy, 16'd1);
    test_random(200, 16'hffff, 1'b0);
    drain();
    $display("Run: %0d words sent, %0d checked; granted %0d, no fit %0d, inserted %0d,",
      words_sent, words_checked, status_seen[fla_pkg::StGranted],
      status_seen[fla_pkg::StNoFit], status_seen[fla_pkg::StInserted]);
    $display("merged next %0d, merged previous %0d, merged both %0d, rejected %0d",
      status_seen[fla_pkg::StMergedNext], status_seen[fla_pkg::StMergedPrev],
      status_seen[fla_pkg::StMergedBoth], status_seen[fla_pkg::StRejected]);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
